FILE: design/dq_pkg.sv
// Shared types and constants for the deque block.
// Used by dq_ctrl, dq_datapath and deque_with_reverse_and_sort.
`timescale 1ns / 1ps
package dq_pkg;

   localparam logic [2:0] KIND_PUSH_BACK  = 3'd0;
   localparam logic [2:0] KIND_POP_BACK   = 3'd1;
   localparam logic [2:0] KIND_PUSH_FRONT = 3'd2;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
   localparam logic [2:0] KIND_CLEAR      = 3'd4;
   localparam logic [2:0] KIND_DUMP       = 3'd5;
   localparam logic [2:0] KIND_REVERSE    = 3'd6;
   localparam logic [2:0] KIND_SORT       = 3'd7;

   localparam logic [1:0] ST_WORD  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP_RD,
      S_POP_OUT,
      S_DUMP_RD,
      S_DUMP_OUT,
      S_SORT_RDA,
      S_SORT_RDB,
      S_SORT_CMP,
      S_SORT_WRB,
      S_STAT_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       accept;      // latch command
      logic       do_push;     // write ring and adjust pointers
      logic       do_clear;
      logic       do_rev;
      logic       pop_rd;      // issue pop read
      logic       pop_commit;  // update pointers after pop
      logic       dump_start;
      logic       dump_next;
      logic       sort_start;
      logic       sort_rdb;
      logic       sort_cmp;    // latch b if in order, else write b to slot a
      logic       sort_wrb;    // write b
      logic       sort_next;
      logic       out_load;    // load output register from read data
      logic [1:0] out_status;
      logic       out_last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
      logic dump_last;    // walk position is final entry
      logic sort_swap;    // current pair out of order
      logic sort_pass_end;
      logic sort_done;
   } stat_type;

endpackage

FILE: design/deque_with_reverse_and_sort.sv
// Deque with reverse and sort: top level, controller plus datapath.
// Push, clear and reverse act when accepted; pop reads RAM, then output reg.
// Dump gives its results in order, each a RAM read then output register.
// Sort compares, and swaps if out of order, n*(n-1)/2 adjacent pairs.
// Synchronous active-high reset empties the queue; store contents undefined.
`timescale 1ns / 1ps
module deque_with_reverse_and_sort #(
   parameter int DEPTH      = 32,
   parameter int WORD_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_value_res,
   output logic               rsp_last
);
   dq_pkg::cmd_type  cmd;
   dq_pkg::stat_type stat;

   dq_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .rsp_ready(rsp_ready), .rsp_valid(rsp_valid),
      .stat(stat), .cmd(cmd)
   );

   dq_datapath #(.DEPTH(DEPTH), .WORD_WIDTH(WORD_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_kind(req_kind), .req_value(req_value),
      .out_status(rsp_status), .out_value(rsp_value_res), .out_last(rsp_last)
   );

`ifndef SYNTH
   a_no_word_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dq_pkg::ST_WORD |-> rsp_value_res == '0 && rsp_last)
      else $error("non-word status with data or without last");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("accepted while result stalled");
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      cmd.do_push |-> !stat.full)
      else $error("push into full ring");
`endif
endmodule

FILE: design/dq_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: design/dq_datapath.sv
// Deque datapath: ring pointers, orientation, walk counters, output register.
// Depends on dq_pkg and dq_ram.
`timescale 1ns / 1ps
module dq_datapath #(
   parameter int DEPTH      = 32,
   parameter int WORD_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  dq_pkg::cmd_type    cmd,
   output dq_pkg::stat_type   stat,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_value,
   output logic [1:0]         out_status,
   output logic signed [31:0] out_value,
   output logic               out_last
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rev_ff, rev_in;
   logic [2:0]    kind_ff;
   logic [CW-1:0] pos_ff, pos_in;     // walk position (dump, sort j)
   logic [CW-1:0] lim_ff, lim_in;     // sort pass limit i
   logic [WORD_WIDTH-1:0] a_ff, b_ff;
   logic [AW-1:0] pop_slot_ff;
   logic [1:0]    ost_ff;
   logic signed [31:0] oval_ff;
   logic          olast_ff;

   logic                  we;
   logic [AW-1:0]         addr;
   logic [WORD_WIDTH-1:0] wdata, rdata;

   dq_ram #(.WIDTH(WORD_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   // modulo-DEPTH add of two values below DEPTH
   function automatic logic [AW-1:0] wrap_add(input logic [CW:0] x, input logic [CW:0] y);
      logic [CW+1:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= (CW+2)'(DEPTH)) s = s - (CW+2)'(DEPTH);
      return s[AW-1:0];
   endfunction

   // physical slot of logical position p
   function automatic logic [AW-1:0] slot_of(input logic [CW-1:0] p,
                                             input logic [AW-1:0] h,
                                             input logic [CW-1:0] c,
                                             input logic r);
      logic [CW-1:0] off;
      off = r ? (c - 1'b1 - p) : p;
      return wrap_add({1'b0, {(CW-AW){1'b0}}, h}, {1'b0, off});
   endfunction

   logic          low_end;     // push at low end of run
   logic [AW-1:0] head_dec;
   logic [AW-1:0] pop_slot;
   logic signed [WORD_WIDTH-1:0] sa, sb;

   assign low_end  = ((req_kind == dq_pkg::KIND_PUSH_BACK) == rev_ff);
   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
   assign pop_slot = (kind_ff == dq_pkg::KIND_POP_FRONT)
                   ? slot_of('0, head_ff, count_ff, rev_ff)
                   : slot_of(count_ff - 1'b1, head_ff, count_ff, rev_ff);
   assign sa = a_ff;
   assign sb = rdata;

   // RAM port steering
   always_comb begin
      we    = 1'b0;
      addr  = slot_of(pos_ff, head_ff, count_ff, rev_ff);
      wdata = rdata;
      if (cmd.do_push) begin
         we    = 1'b1;
         addr  = low_end ? head_dec
                         : wrap_add({1'b0, {(CW-AW){1'b0}}, head_ff}, {1'b0, count_ff});
         wdata = WORD_WIDTH'(req_value);
      end else if (cmd.pop_rd) begin
         addr = pop_slot;
      end else if (cmd.sort_rdb) begin
         addr = slot_of(pos_ff + 1'b1, head_ff, count_ff, rev_ff);
      end else if (cmd.sort_cmp) begin
         we    = (sa > sb);
         addr  = slot_of(pos_ff, head_ff, count_ff, rev_ff);
         wdata = rdata;
      end else if (cmd.sort_wrb) begin
         we    = 1'b1;
         addr  = slot_of(pos_ff + 1'b1, head_ff, count_ff, rev_ff);
         wdata = a_ff;
      end
   end

   // pointer and counter updates
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      rev_in   = rev_ff;
      pos_in   = pos_ff;
      lim_in   = lim_ff;
      if (cmd.do_push) begin
         if (low_end) head_in = head_dec;
         count_in = count_ff + 1'b1;
      end
      if (cmd.pop_commit) begin
         if (pop_slot_ff == head_ff)
            head_in = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
      if (cmd.do_clear) count_in = '0;
      if (cmd.do_rev)   rev_in   = ~rev_ff;
      if (cmd.dump_start) pos_in = '0;
      if (cmd.dump_next)  pos_in = pos_ff + 1'b1;
      if (cmd.sort_start) begin
         pos_in = '0;
         lim_in = count_ff;
      end
      if (cmd.sort_next) begin
         if (stat.sort_pass_end) begin
            pos_in = '0;
            lim_in = lim_ff - 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
         pos_ff   <= '0;
         lim_ff   <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
         pos_ff   <= pos_in;
         lim_ff   <= lim_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) kind_ff <= req_kind;
      if (cmd.pop_rd) pop_slot_ff <= pop_slot;
      if (cmd.sort_cmp) a_ff <= (sa > sb) ? a_ff : rdata;
      else if (cmd.sort_rdb) a_ff <= rdata;
      if (cmd.out_load) begin
         ost_ff   <= cmd.out_status;
         olast_ff <= cmd.out_last;
         oval_ff  <= (cmd.out_status == dq_pkg::ST_WORD) ? 32'(sb) : '0;
      end
   end

   // status to controller; sort ends once fewer than two entries remain in the pass
   always_comb begin
      stat.full          = (count_ff == CW'(DEPTH));
      stat.empty         = (count_ff == '0);
      stat.dump_last     = (pos_ff + 1'b1 == count_ff);
      stat.sort_swap     = (sa > sb);
      stat.sort_pass_end = (pos_ff + 2'd2 >= lim_ff);
      stat.sort_done     = (lim_ff <= CW'(1));
   end

   assign out_status = ost_ff;
   assign out_value  = oval_ff;
   assign out_last   = olast_ff;
endmodule

FILE: design/dq_ctrl.sv
// Deque controller: sequences commands and the output handshake.
// Depends on dq_pkg.
`timescale 1ns / 1ps
module dq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_kind,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   input  dq_pkg::stat_type stat,
   output dq_pkg::cmd_type  cmd
);
   dq_pkg::state_type state_ff, state_in;
   logic valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dq_pkg::S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // next state and commands
   always_comb begin
      logic acc, out_free;
      state_in  = state_ff;
      cmd       = '0;
      out_free  = !valid_ff || rsp_ready;
      valid_in  = valid_ff && !rsp_ready;
      req_ready = (state_ff == dq_pkg::S_IDLE) && out_free;
      acc       = req_ready && req_valid;
      case (state_ff)
         dq_pkg::S_IDLE: begin
            if (acc) begin
               cmd.accept = 1'b1;
               case (req_kind)
                  dq_pkg::KIND_PUSH_BACK, dq_pkg::KIND_PUSH_FRONT: begin
                     if (stat.full) begin
                        cmd.out_load = 1'b1; cmd.out_status = dq_pkg::ST_FULL;
                        cmd.out_last = 1'b1; valid_in = 1'b1;
                     end else begin
                        cmd.do_push = 1'b1;
                     end
                  end
                  dq_pkg::KIND_POP_BACK, dq_pkg::KIND_POP_FRONT: begin
                     if (stat.empty) begin
                        cmd.out_load = 1'b1; cmd.out_status = dq_pkg::ST_EMPTY;
                        cmd.out_last = 1'b1; valid_in = 1'b1;
                     end else begin
                        state_in = dq_pkg::S_POP_RD;
                     end
                  end
                  dq_pkg::KIND_CLEAR:   cmd.do_clear = 1'b1;
                  dq_pkg::KIND_REVERSE: cmd.do_rev = 1'b1;
                  dq_pkg::KIND_DUMP: begin
                     if (stat.empty) begin
                        cmd.out_load = 1'b1; cmd.out_status = dq_pkg::ST_EMPTY;
                        cmd.out_last = 1'b1; valid_in = 1'b1;
                     end else begin
                        cmd.dump_start = 1'b1;
                        state_in = dq_pkg::S_DUMP_RD;
                     end
                  end
                  default: begin
                     cmd.sort_start = 1'b1;
                     state_in = dq_pkg::S_SORT_RDA;
                  end
               endcase
            end
         end
         // kind_ff latched; issue read of pop slot
         dq_pkg::S_POP_RD: begin
            cmd.pop_rd = 1'b1;
            state_in = dq_pkg::S_POP_OUT;
         end
         dq_pkg::S_POP_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1; cmd.out_status = dq_pkg::ST_WORD;
               cmd.out_last = 1'b1; valid_in = 1'b1;
               cmd.pop_commit = 1'b1;
               state_in = dq_pkg::S_IDLE;
            end
         end
         dq_pkg::S_DUMP_RD: state_in = dq_pkg::S_DUMP_OUT;
         dq_pkg::S_DUMP_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1; cmd.out_status = dq_pkg::ST_WORD;
               cmd.out_last = stat.dump_last; valid_in = 1'b1;
               if (stat.dump_last) begin
                  state_in = dq_pkg::S_IDLE;
               end else begin
                  cmd.dump_next = 1'b1;
                  state_in = dq_pkg::S_DUMP_RD;
               end
            end
         end
         // sort: read a (pos), read b (pos+1), compare/write a, write b
         dq_pkg::S_SORT_RDA: begin
            if (stat.sort_done) begin
               state_in = dq_pkg::S_IDLE;
            end else begin
               state_in = dq_pkg::S_SORT_RDB;
            end
         end
         dq_pkg::S_SORT_RDB: begin
            cmd.sort_rdb = 1'b1;
            state_in = dq_pkg::S_SORT_CMP;
         end
         dq_pkg::S_SORT_CMP: begin
            cmd.sort_cmp = 1'b1;
            if (stat.sort_swap) begin
               state_in = dq_pkg::S_SORT_WRB;
            end else begin
               cmd.sort_next = 1'b1;
               state_in = dq_pkg::S_SORT_RDA;
            end
         end
         dq_pkg::S_SORT_WRB: begin
            cmd.sort_wrb = 1'b1;
            cmd.sort_next = 1'b1;
            state_in = dq_pkg::S_SORT_RDA;
         end
         default: state_in = dq_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid = valid_ff;
endmodule

FILE: tb/deque_with_reverse_and_sort_tb.sv
// Testbench for deque_with_reverse_and_sort: directed and random commands.
// Depends on dq_pkg and the deque RTL; a scoreboard class predicts results.
`timescale 1ns / 1ps
module deque_with_reverse_and_sort_tb;

   localparam int DEPTH = 32;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] word;
      logic               last;
   } deque_result_type;

   int error_count = 0;

   task automatic report_mismatch(input string what, input deque_result_type got,
                                  input deque_result_type want);
      $display("MISMATCH %s: got st=%0d v=%0d l=%0b, want st=%0d v=%0d l=%0b",
               what, got.status, got.word, got.last, want.status, want.word, want.last);
      error_count++;
   endtask

   // Scoreboard: shadow deque plus queue of pending results
   class deque_scoreboard;
      logic signed [31:0] ring [DEPTH];
      int unsigned head = 0;
      int unsigned count = 0;
      bit flipped = 0;
      deque_result_type pending[$];

      function int unsigned slot_at(int unsigned pos);
         if (!flipped) return (head + pos) % DEPTH;
         return (head + count - 1 - pos) % DEPTH;
      endfunction

      function void add_result(logic [1:0] st, logic signed [31:0] w, logic fin);
         deque_result_type r;
         r.status = st;
         r.word = (st == dq_pkg::ST_WORD) ? w : '0;
         r.last = fin;
         pending.push_back(r);
      endfunction

      function void note_command(logic [2:0] kind, logic signed [31:0] value);
         int unsigned s, a, b;
         logic signed [31:0] t;
         case (kind)
            dq_pkg::KIND_PUSH_BACK, dq_pkg::KIND_PUSH_FRONT: begin
               if (count >= DEPTH) begin
                  add_result(dq_pkg::ST_FULL, 0, 1);
               end else begin
                  if ((kind == dq_pkg::KIND_PUSH_BACK) == flipped) begin
                     head = (head + DEPTH - 1) % DEPTH;
                     s = head;
                  end else begin
                     s = (head + count) % DEPTH;
                  end
                  ring[s] = value;
                  count++;
               end
            end
            dq_pkg::KIND_POP_BACK, dq_pkg::KIND_POP_FRONT: begin
               if (count == 0) begin
                  add_result(dq_pkg::ST_EMPTY, 0, 1);
               end else begin
                  s = (kind == dq_pkg::KIND_POP_FRONT) ? slot_at(0) : slot_at(count - 1);
                  add_result(dq_pkg::ST_WORD, ring[s], 1);
                  if (s == head) head = (head + 1) % DEPTH;
                  count--;
               end
            end
            dq_pkg::KIND_CLEAR: count = 0;
            dq_pkg::KIND_DUMP: begin
               if (count == 0) add_result(dq_pkg::ST_EMPTY, 0, 1);
               for (int unsigned i = 0; i < count; i++)
                  add_result(dq_pkg::ST_WORD, ring[slot_at(i)], i + 1 == count);
            end
            dq_pkg::KIND_REVERSE: flipped = !flipped;
            default: begin
               for (int unsigned i = count; i > 1; i--)
                  for (int unsigned j = 0; j + 1 < i; j++) begin
                     a = slot_at(j);
                     b = slot_at(j + 1);
                     if (ring[a] > ring[b]) begin
                        t = ring[a];
                        ring[a] = ring[b];
                        ring[b] = t;
                     end
                  end
            end
         endcase
      endfunction

      task check_result(deque_result_type got);
         deque_result_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected transaction", got, got);
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) report_mismatch("status", got, want);
         if (got.word !== want.word) report_mismatch("value_res", got, want);
         if (got.last !== want.last) report_mismatch("last", got, want);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_kind = '0;
   logic signed [31:0] req_value = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_value_res;
   logic rsp_last;
   int cycle_count = 0;
   deque_scoreboard board = new();

   deque_with_reverse_and_sort u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_value_res(rsp_value_res), .rsp_last(rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Bound on run time
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("deque_with_reverse_and_sort_tb: done, errors");
         $finish;
      end
   end

   // Result side: sample accepted transactions, stall on a pattern
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_result({rsp_status, rsp_value_res, rsp_last});
         case (cycle_count[9:8])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= cycle_count[2] | cycle_count[0];
         endcase
      end
   end

   int gap_left = 0;
   int burst_left = 0;

   // Send one command; bursts with random gaps between them
   task automatic send_command(input logic [2:0] kind, input logic signed [31:0] value);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            repeat (gap_left) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_command(kind, value);
   endtask

   function automatic logic signed [31:0] random_word();
      case ($urandom_range(0, 4))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(0, 15)) - 8;
         default: return $signed($urandom());
      endcase
   endfunction

   initial begin
      logic [2:0] k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty cases, extremes, reverse, sort, full ring
      send_command(dq_pkg::KIND_POP_BACK, 0);
      send_command(dq_pkg::KIND_POP_FRONT, 0);
      send_command(dq_pkg::KIND_DUMP, 0);
      send_command(dq_pkg::KIND_REVERSE, 0);
      send_command(dq_pkg::KIND_SORT, 0);
      send_command(dq_pkg::KIND_REVERSE, 0);
      send_command(dq_pkg::KIND_PUSH_BACK, 32'sh7FFFFFFF);
      send_command(dq_pkg::KIND_SORT, 0);
      send_command(dq_pkg::KIND_PUSH_FRONT, 32'sh80000000);
      send_command(dq_pkg::KIND_PUSH_BACK, -1);
      send_command(dq_pkg::KIND_PUSH_FRONT, 0);
      send_command(dq_pkg::KIND_DUMP, 0);
      send_command(dq_pkg::KIND_REVERSE, 0);
      send_command(dq_pkg::KIND_DUMP, 0);
      send_command(dq_pkg::KIND_SORT, 0);
      send_command(dq_pkg::KIND_DUMP, 0);
      send_command(dq_pkg::KIND_POP_FRONT, 0);
      send_command(dq_pkg::KIND_POP_BACK, 0);
      send_command(dq_pkg::KIND_CLEAR, 0);
      send_command(dq_pkg::KIND_DUMP, 0);
      for (int i = 0; i < DEPTH + 2; i++)
         send_command(i[0] ? dq_pkg::KIND_PUSH_FRONT : dq_pkg::KIND_PUSH_BACK,
                      random_word());
      send_command(dq_pkg::KIND_SORT, 0);
      send_command(dq_pkg::KIND_DUMP, 0);
      send_command(dq_pkg::KIND_CLEAR, 0);

      // Random: push-heavy mix so the ring fills and wraps
      for (int n = 0; n < 115; n++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: k = dq_pkg::KIND_PUSH_BACK;
            6, 7, 8, 9: k = dq_pkg::KIND_PUSH_FRONT;
            10, 11: k = dq_pkg::KIND_POP_BACK;
            12, 13: k = dq_pkg::KIND_POP_FRONT;
            14: k = ($urandom_range(0, 3) == 0) ? dq_pkg::KIND_CLEAR : dq_pkg::KIND_REVERSE;
            15, 16: k = dq_pkg::KIND_DUMP;
            17: k = dq_pkg::KIND_REVERSE;
            default: k = dq_pkg::KIND_SORT;
         endcase
         send_command(k, random_word());
      end
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("deque_with_reverse_and_sort_tb: done, clean");
      else
         $display("deque_with_reverse_and_sort_tb: done, errors");
      $finish;
   end
endmodule
